// ===== rtl/hbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbw_pkg;

  // Pipeline geometry.
  localparam int unsigned EXP_TERMS = 10;
  localparam int unsigned EXP_LAT   = 1 + 3 * EXP_TERMS;
  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned LOG_LAT   = LOG_STEPS + 2;
  localparam int unsigned DIV_STEPS = 16;

  // Cycles the derived curve needs after reset or a register write.
  localparam logic [5:0] CFG_SETTLE = 6'd40;

  // Fixed-point constants.
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [17:0] LOG2E_X2_Q16  = 18'd189096;
  localparam logic [29:0] CEIL_NUM      = 30'd654376960;
  localparam logic [13:0] START_SCALE   = 14'd10000;
  localparam logic [32:0] ONE_Q32       = 33'h1_0000_0000;
  localparam logic [32:0] START_MAX_Q32 = 33'd4290672329;
  localparam logic [31:0] MIN_SPAN_Q32  = 32'd8589935;
  localparam logic [31:0] WIDTH_EPS_Q32 = 32'd4295;
  localparam logic [17:0] SMOOTH_THREE  = 18'd196608;

  // Reciprocals for division by small constants: floor(2^24 / d).
  localparam logic [20:0] RECIP15_Q24 = 21'd1118481;
  localparam logic [21:0] RECIP5_Q24  = 22'd3355443;

  // Reciprocals floor(2^32 / n) for the series terms.
  localparam logic [32:0] EXP_RECIP [1:EXP_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729
  };

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_DELAY  = 2'd1,
    REG_SMOOTH = 2'd2
  } reg_idx_e;

  // Early-out decisions that travel with a sample.
  typedef struct packed {
    logic lo;  // at or below the window
    logic hi;  // at or above the window
    logic tz;  // window fraction truncated to zero
  } flags_t;

  typedef struct packed {
    flags_t     flags;
    logic [7:0] ip;
    logic       fpz;
  } pow_side_t;

endpackage

`default_nettype wire

// ===== rtl/hbw_exp2frac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 2^g for g in Q16 [0,1), result in Q30, by a ten-term series for e^(g ln 2).
// One setup stage and three stages per term.
module hbw_exp2frac (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] frac_i,
  output logic      [31:0] pow_o
);

  logic [29:0] z_q    [0:hbw_pkg::EXP_TERMS-1];
  logic [30:0] term_q [0:hbw_pkg::EXP_TERMS-1];
  logic [31:0] sum_q  [0:hbw_pkg::EXP_TERMS];
  logic [45:0] zprod;

  assign zprod = 46'(frac_i) * 46'(hbw_pkg::LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= zprod[45:16];
      term_q[0] <= 31'h4000_0000;
      sum_q[0]  <= 32'h4000_0000;
    end
  end

  for (genvar n = 1; n <= hbw_pkg::EXP_TERMS; n++) begin : g_term
    logic [29:0] za_q, zb_q, a_q, ab_q, q0_q;
    logic [31:0] sa_q, sb_q;
    logic [60:0] aprod;
    logic [62:0] bprod;
    logic [33:0] nq, rem;
    logic [29:0] q;

    assign aprod = 61'(term_q[n-1]) * 61'(z_q[n-1]);
    assign bprod = 63'(a_q) * 63'(hbw_pkg::EXP_RECIP[n]);
    assign nq    = 34'(q0_q) * 34'(n);
    assign rem   = 34'(ab_q) - nq;
    assign q     = (rem >= 34'(n)) ? q0_q + 30'd1 : q0_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q      <= aprod[59:30];
        za_q     <= z_q[n-1];
        sa_q     <= sum_q[n-1];
        q0_q     <= bprod[61:32];
        ab_q     <= a_q;
        zb_q     <= za_q;
        sb_q     <= sa_q;
        sum_q[n] <= sb_q + 32'(q);
      end
    end

    if (n < hbw_pkg::EXP_TERMS) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          term_q[n] <= {1'b0, q};
          z_q[n]    <= zb_q;
        end
      end
    end else begin : g_last
      logic unused_z;
      assign unused_z = ^zb_q;
    end
  end

  assign pow_o = sum_q[hbw_pkg::EXP_TERMS];

endmodule

`default_nettype wire

// ===== rtl/hbw_neglog2.sv =====
`timescale 1ns / 1ps
`default_nettype none

// -log2(t) in Q16 for t in 1..65535. The integer part comes from the leading
// one; each fraction bit comes from one squaring of the Q30 mantissa.
module hbw_neglog2 (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] t_i,
  output logic      [20:0] nlog_o
);

  logic [3:0]  lead;
  logic [30:0] norm;
  logic [30:0] m_q  [0:hbw_pkg::LOG_STEPS-1];
  logic [15:0] f_q  [0:hbw_pkg::LOG_STEPS];
  logic [4:0]  ip_q [0:hbw_pkg::LOG_STEPS];
  logic [20:0] nlog_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (t_i[i]) begin
        lead = 4'(i);
      end
    end
  end

  assign norm = 31'(t_i) << (5'd30 - 5'(lead));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= norm;
      f_q[0]  <= '0;
      ip_q[0] <= 5'd16 - 5'(lead);
    end
  end

  for (genvar i = 1; i <= hbw_pkg::LOG_STEPS; i++) begin : g_sq
    localparam logic [15:0] FBIT = 16'(1) << (hbw_pkg::LOG_STEPS - i);
    logic [61:0] sq;
    logic [31:0] m2;

    assign sq = 62'(m_q[i-1]) * 62'(m_q[i-1]);
    assign m2 = sq[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i]  <= m2[31] ? (f_q[i-1] | FBIT) : f_q[i-1];
        ip_q[i] <= ip_q[i-1];
      end
    end

    if (i < hbw_pkg::LOG_STEPS) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[i] <= m2[31] ? m2[31:1] : m2[30:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nlog_q <= {ip_q[hbw_pkg::LOG_STEPS], 16'd0} - 21'(f_q[hbw_pkg::LOG_STEPS]);
    end
  end

  assign nlog_o = nlog_q;

endmodule

`default_nettype wire

// ===== rtl/highlight_blend_weight_curve.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Highlight blend weight curve. Each brightness sample on the slave stream
// (Q1.16, tdata[16:0]) yields one blend weight on the master stream (Q1.16,
// tdata[16:0]), 0 at or below a window, 1.0 at or above it and t^k inside it.
// Three registers on the APB port set the curve: start at 0x0, delay at 0x4,
// smoothness at 0x8; reads return the stored values, pready is always high.
// One sample is taken every cycle while the output does not stall and no
// settling is pending. The sample path runs through the 16-step restoring
// divider, the 16 mantissa squarings of the log unit and the 31 stages of
// the series exp unit.
// The whole sample pipeline advances together: when a weight waits on the
// output register and tready is low, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated. A bubble on the output lets it move.
// The window bounds and the exponent are derived from the registers by a
// separate free-running pipeline. After reset and after every APB write
// s_axis_tready stays low while the settle counter lets that pipeline settle.
// Reset clears the registers and all valid bits.
module highlight_blend_weight_curve (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [16:0] s_level, rest zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata    // [16:0] blend_weight, rest zero
);

  localparam int unsigned DEPTH = 2 + hbw_pkg::DIV_STEPS + hbw_pkg::LOG_LAT + 1
                                  + hbw_pkg::EXP_LAT + 1;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [16:0] start_q, start_d, delay_q, delay_d, smooth_q, smooth_d;
  logic [5:0]  settle_q, settle_d;
  logic        cfg_wr;
  hbw_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = hbw_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    start_d  = start_q;
    delay_d  = delay_q;
    smooth_d = smooth_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        hbw_pkg::REG_START:  start_d  = pwdata[16:0];
        hbw_pkg::REG_DELAY:  delay_d  = pwdata[16:0];
        hbw_pkg::REG_SMOOTH: smooth_d = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hbw_pkg::REG_START:  prdata = 32'(start_q);
      hbw_pkg::REG_DELAY:  prdata = 32'(delay_q);
      hbw_pkg::REG_SMOOTH: prdata = 32'(smooth_q);
      default:             prdata = '0;
    endcase
  end

  // Hold off samples until the derived curve reflects the registers.
  always_comb begin
    if (cfg_wr) begin
      settle_d = hbw_pkg::CFG_SETTLE;
    end else if (settle_q != 6'd0) begin
      settle_d = settle_q - 6'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      delay_q  <= '0;
      smooth_q <= '0;
      settle_q <= hbw_pkg::CFG_SETTLE;
    end else begin
      start_q  <= start_d;
      delay_q  <= delay_d;
      smooth_q <= smooth_d;
      settle_q <= settle_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Curve derivation, each cycle. Change inputs only while idle; not enforced.
  // ---------------------------------------------------------------------------
  logic [16:0] c1_st_q, c1_dl_q, c1_sm_q;
  logic [29:0] c1_prod_q;
  logic        c2_hi_q;
  logic [19:0] c2_n_q;
  logic [17:0] c2_e_q;
  logic [16:0] c3_u0_q, c4_u_q, c5_u_q, c5_u2_q, c6_decay_q;
  logic [33:0] c7_p2_q;
  logic [14:0] c8_qh0_q, c9_qh_q;
  logic [16:0] c8_nh_q, c8_nl_q, c9_nl_q, c10_ql0_q;
  logic [2:0]  c9_rh_q;
  logic [19:0] c10_v_q;
  logic [31:0] c11_w_q, c12_wm_q;
  logic        c12_zero_q;
  logic [32:0] c12_bs_q, c13_be_q, c14_span_q;
  logic [18:0] ck_q;

  logic [16:0] st_sat, dl_sat, sm_sat;
  logic [34:0] e_prod;
  logic [40:0] u0_prod;
  logic [20:0] u_rem;
  logic [33:0] u2_prod;
  logic [17:0] s_fac;
  logic [34:0] s_prod;
  logic [18:0] s_val;
  logic [33:0] p_prod;
  logic [38:0] qh_prod;
  logic [16:0] rh_rem;
  logic [41:0] ql_prod;
  logic [19:0] ql_rem;
  logic [16:0] ql;
  logic [32:0] bs_raw;
  logic [33:0] be_sum;
  logic [31:0] k_pow;
  logic [33:0] k_shift;

  assign st_sat  = (start_q > hbw_pkg::ONE_Q16) ? hbw_pkg::ONE_Q16 : start_q;
  assign dl_sat  = (delay_q > hbw_pkg::ONE_Q16) ? hbw_pkg::ONE_Q16 : delay_q;
  assign sm_sat  = (smooth_q > hbw_pkg::ONE_Q16) ? hbw_pkg::ONE_Q16 : smooth_q;
  assign e_prod  = 35'(c1_sm_q) * 35'(hbw_pkg::LOG2E_X2_Q16);
  assign u0_prod = 41'(c2_n_q) * 41'(hbw_pkg::RECIP15_Q24);
  assign u_rem   = 21'(c2_n_q) - 21'(c3_u0_q) * 21'd15;
  assign u2_prod = 34'(c4_u_q) * 34'(c4_u_q);
  assign s_fac   = hbw_pkg::SMOOTH_THREE - {c5_u_q, 1'b0};
  assign s_prod  = 35'(c5_u2_q) * 35'(s_fac);
  assign s_val   = s_prod[34:16];
  assign p_prod  = 34'(c1_dl_q) * 34'(c6_decay_q);
  assign qh_prod = 39'(c7_p2_q[33:17]) * 39'(hbw_pkg::RECIP5_Q24);
  assign rh_rem  = c8_nh_q - 17'(c8_qh0_q) * 17'd5;
  assign ql_prod = 42'(c10_v_q) * 42'(hbw_pkg::RECIP5_Q24);
  assign ql_rem  = c10_v_q - 20'(c10_ql0_q) * 20'd5;
  assign ql      = (ql_rem >= 20'd5) ? c10_ql0_q + 17'd1 : c10_ql0_q;
  assign bs_raw  = {c1_st_q, 16'd0};
  assign be_sum  = 34'(c12_bs_q) + 34'(c12_wm_q);
  assign k_shift = 34'(k_pow) << c2_e_q[17:16];

  always_ff @(posedge clk_i) begin
    c1_st_q   <= st_sat;
    c1_dl_q   <= dl_sat;
    c1_sm_q   <= sm_sat;
    c1_prod_q <= 30'(st_sat) * 30'(hbw_pkg::START_SCALE);

    // Smoothstep decay of the width when start lies above 0.9985.
    c2_hi_q   <= c1_prod_q > hbw_pkg::CEIL_NUM;
    c2_n_q    <= (c1_prod_q > hbw_pkg::CEIL_NUM) ? 20'(c1_prod_q - hbw_pkg::CEIL_NUM)
                                                 : 20'd0;
    c2_e_q    <= e_prod[33:16];
    c3_u0_q   <= u0_prod[40:24];
    c4_u_q    <= (u_rem >= 21'd15) ? c3_u0_q + 17'd1 : c3_u0_q;
    c5_u_q    <= c4_u_q;
    c5_u2_q   <= u2_prod[32:16];
    if (!c2_hi_q) begin
      c6_decay_q <= hbw_pkg::ONE_Q16;
    end else if (s_val > 19'(hbw_pkg::ONE_Q16)) begin
      c6_decay_q <= '0;
    end else begin
      c6_decay_q <= hbw_pkg::ONE_Q16 - s_val[16:0];
    end

    // Width 2*delay*decay/5 in Q32, divided as two 17-bit halves.
    c7_p2_q   <= {p_prod[32:0], 1'b0};
    c8_qh0_q  <= qh_prod[38:24];
    c8_nh_q   <= c7_p2_q[33:17];
    c8_nl_q   <= c7_p2_q[16:0];
    c9_qh_q   <= (rh_rem >= 17'd5) ? c8_qh0_q + 15'd1 : c8_qh0_q;
    c9_rh_q   <= (rh_rem >= 17'd5) ? 3'(rh_rem - 17'd5) : 3'(rh_rem);
    c9_nl_q   <= c8_nl_q;
    c10_v_q   <= {c9_rh_q, c9_nl_q};
    c10_ql0_q <= ql_prod[40:24];
    c11_w_q   <= {c9_qh_q, 17'd0} + 32'(ql);

    // Window bounds in Q32.
    c12_zero_q <= c11_w_q < hbw_pkg::WIDTH_EPS_Q32;
    if (c11_w_q < hbw_pkg::WIDTH_EPS_Q32) begin
      c12_bs_q <= hbw_pkg::ONE_Q32;
    end else begin
      c12_bs_q <= (bs_raw > hbw_pkg::START_MAX_Q32) ? hbw_pkg::START_MAX_Q32 : bs_raw;
    end
    c12_wm_q <= (c11_w_q < hbw_pkg::MIN_SPAN_Q32) ? hbw_pkg::MIN_SPAN_Q32 : c11_w_q;
    if (c12_zero_q || be_sum > 34'(hbw_pkg::ONE_Q32)) begin
      c13_be_q <= hbw_pkg::ONE_Q32;
    end else begin
      c13_be_q <= be_sum[32:0];
    end
    c14_span_q <= c13_be_q - c12_bs_q;

    // Exponent k = 2^(2*smoothness*log2(e)) in Q16.
    ck_q <= k_shift[32:14];
  end

  hbw_exp2frac u_cfg_exp (
    .clk_i  (clk_i),
    .en_i   (1'b1),
    .frac_i (c2_e_q[15:0]),
    .pow_o  (k_pow)
  );

  // ---------------------------------------------------------------------------
  // Sample pipeline
  // ---------------------------------------------------------------------------
  logic             en;
  logic [DEPTH-1:0] vld_q;
  logic             in_acc;

  assign en            = ~vld_q[DEPTH-1] | m_axis_tready;
  assign s_axis_tready = en & (settle_q == 6'd0);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_acc};
    end
  end

  // Window compare and first divider remainder.
  logic [16:0] x1_q;
  logic [32:0] x16;

  assign x16 = {x1_q, 16'd0};

  logic [32:0]     dr_q [0:hbw_pkg::DIV_STEPS-1];
  logic [15:0]     dq_q [0:hbw_pkg::DIV_STEPS];
  hbw_pkg::flags_t df_q [0:hbw_pkg::DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= s_axis_tdata[16:0];
      dr_q[0]  <= x16 - c12_bs_q;
      dq_q[0]  <= '0;
      df_q[0]  <= '{lo: x16 <= c12_bs_q, hi: x16 >= c13_be_q, tz: 1'b0};
    end
  end

  // Restoring division: one quotient bit of (x - bs) / span per stage.
  for (genvar d = 1; d <= hbw_pkg::DIV_STEPS; d++) begin : g_div
    logic [33:0] r2;
    logic        ge;

    assign r2 = {dr_q[d-1], 1'b0};
    assign ge = r2 >= 34'(c14_span_q);

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq_q[d] <= {dq_q[d-1][14:0], ge};
        df_q[d] <= df_q[d-1];
      end
    end

    if (d < hbw_pkg::DIV_STEPS) begin : g_rem
      logic [33:0] rn;
      assign rn = ge ? r2 - 34'(c14_span_q) : r2;
      always_ff @(posedge clk_i) begin
        if (en) begin
          dr_q[d] <= rn[32:0];
        end
      end
    end
  end

  // -log2(t), flags riding alongside.
  logic [15:0]     t_val;
  logic [20:0]     nlog;
  hbw_pkg::flags_t lf_q [0:hbw_pkg::LOG_LAT-1];

  assign t_val = dq_q[hbw_pkg::DIV_STEPS];

  hbw_neglog2 u_log (
    .clk_i  (clk_i),
    .en_i   (en),
    .t_i    (t_val),
    .nlog_o (nlog)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lf_q[0] <= '{lo: df_q[hbw_pkg::DIV_STEPS].lo, hi: df_q[hbw_pkg::DIV_STEPS].hi,
                   tz: t_val == 16'd0};
      for (int i = 1; i < hbw_pkg::LOG_LAT; i++) begin
        lf_q[i] <= lf_q[i-1];
      end
    end
  end

  // M = k * L, split into integer and fraction of the power of two.
  logic [39:0]     m_prod;
  logic [7:0]      ip_q;
  logic [15:0]     fp_q;
  hbw_pkg::flags_t mf_q;
  logic [16:0]     g_full;
  logic [31:0]     frac_pow;

  assign m_prod = 40'(ck_q) * 40'(nlog);
  assign g_full = hbw_pkg::ONE_Q16 - 17'(fp_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ip_q <= m_prod[39:32];
      fp_q <= m_prod[31:16];
      mf_q <= lf_q[hbw_pkg::LOG_LAT-1];
    end
  end

  hbw_exp2frac u_pow_exp (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (g_full[15:0]),
    .pow_o  (frac_pow)
  );

  hbw_pkg::pow_side_t ps_q [0:hbw_pkg::EXP_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= '{flags: mf_q, ip: ip_q, fpz: fp_q == 16'd0};
      for (int i = 1; i < hbw_pkg::EXP_LAT; i++) begin
        ps_q[i] <= ps_q[i-1];
      end
    end
  end

  // Output register: 2^-M with the window decisions applied.
  hbw_pkg::pow_side_t side;
  logic [31:0] pow_val, pow_shr;
  logic [8:0]  sh;
  logic [16:0] weight_d, weight_q;

  assign side    = ps_q[hbw_pkg::EXP_LAT-1];
  assign pow_val = side.fpz ? 32'h4000_0000 : frac_pow;
  assign sh      = 9'(side.ip) + (side.fpz ? 9'd14 : 9'd15);
  assign pow_shr = pow_val >> sh[4:0];

  always_comb begin
    priority if (side.flags.lo) begin
      weight_d = '0;
    end else if (side.flags.hi) begin
      weight_d = hbw_pkg::ONE_Q16;
    end else if (side.flags.tz || sh >= 9'd31) begin
      weight_d = '0;
    end else begin
      weight_d = pow_shr[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      weight_q <= weight_d;
    end
  end

  assign m_axis_tdata = {7'd0, weight_q};

endmodule

`default_nettype wire

// ===== sim/highlight_blend_weight_curve_tb.sv =====
`timescale 1ns / 1ps

module highlight_blend_weight_curve_tb;

  localparam int unsigned PIPE_LAT = 69;
  localparam int unsigned LONG_HOLD = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [16:0] s_level, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [16:0] blend_weight, rest zero

  highlight_blend_weight_curve DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Local copy of the curve registers, as the block stores them.
  logic [16:0] cur_start, cur_delay, cur_smooth;

  logic [16:0] level_q[$];    // samples waiting to be offered
  logic [16:0] weight_q[$];   // weights the block still owes us

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit          gaps_on = 1'b1;
  bit          sender_pause = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // 2^g for a Q16 fraction g, as a Q30 value, by ten terms of the e^z series.
  function automatic logic [63:0] pow2_frac(input logic [63:0] g);
    logic [63:0] z, term, acc;
    z = ((g & 64'hFFFF) * 64'd744261118) >> 16;
    term = 64'd1 << 30;
    acc = term;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * z) >> 30) / n;
      acc += term;
    end
    return acc;
  endfunction

  // -log2(t) in Q16 for t in 1..65535: leading one, then mantissa squaring.
  function automatic logic [63:0] neg_log2_q16(input logic [63:0] t);
    int unsigned p;
    logic [63:0] m, frac;
    p = 0;
    frac = 0;
    for (int i = 0; i < 16; i++) if (t[i]) p = i;
    m = t << (30 - p);
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 64'd1 << (16 - i);
      end
    end
    return 64'(16 - p) * 64'd65536 - frac;
  endfunction

  function automatic logic [63:0] clamp_one(input logic [16:0] v);
    return (v > 17'd65536) ? 64'd65536 : 64'(v);
  endfunction

  // Expected blend weight for one sample under the current registers.
  function automatic logic [16:0] blend_weight_for(input logic [16:0] level);
    logic [63:0] st, dl, sm, decay, u, u2, sq, w32, lo_b, hi_b, x, t;
    logic [63:0] lg, e, k, m, ip, fp, val, sh;
    st = clamp_one(cur_start);
    dl = clamp_one(cur_delay);
    sm = clamp_one(cur_smooth);
    decay = 64'd65536;
    if (st * 10000 > 64'd654376960) begin
      u = (st * 10000 - 64'd654376960) / 15;
      u2 = (u * u) >> 16;
      sq = (u2 * (64'd196608 - 2 * u)) >> 16;
      if (sq > 64'd65536) sq = 64'd65536;
      decay = 64'd65536 - sq;
    end
    w32 = dl * decay * 2 / 5;
    if (w32 < 64'd4295) begin
      lo_b = 64'd1 << 32;
      hi_b = lo_b;
    end else begin
      lo_b = st << 16;
      if (lo_b > 64'd4290672329) lo_b = 64'd4290672329;
      hi_b = lo_b + w32;
      if (hi_b < lo_b + 64'd8589935) hi_b = lo_b + 64'd8589935;
      if (hi_b > (64'd1 << 32)) hi_b = 64'd1 << 32;
    end
    x = 64'(level) << 16;
    if (x <= lo_b) return 17'd0;
    if (x >= hi_b) return 17'd65536;
    t = ((x - lo_b) << 16) / (hi_b - lo_b);
    if (t == 0) return 17'd0;
    if (t > 64'hFFFF) t = 64'hFFFF;
    lg = neg_log2_q16(t);
    e = (2 * sm * 64'd94548) >> 16;
    k = (pow2_frac(e & 64'hFFFF) << (e >> 16)) >> 14;
    m = (k * lg) >> 16;
    ip = m >> 16;
    fp = m & 64'hFFFF;
    if (fp == 0) begin
      val = 64'd1 << 30;
      sh = ip + 14;
    end else begin
      val = pow2_frac(64'd65536 - fp);
      sh = ip + 15;
    end
    if (sh >= 31) return 17'd0;
    return 17'(val >> sh);
  endfunction

  // Driver: bursts of samples, with random gaps while gaps_on is set; the prediction is made as
  // each transaction is accepted, so it always uses the registers in force.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        weight_q.push_back(blend_weight_for(s_axis_tdata[16:0]));
        void'(level_q.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Hold the offered transaction until it is taken.
      end else if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else begin
        // The queue head is always the next sample to offer.
        if (!sender_pause && level_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, level_q[0]};
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            if (gaps_on) gap_left <= $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request that
  // it counts out itself.
  int unsigned stall_phase = 0;
  int unsigned hold_cnt = 0;
  bit          hold_taken = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase <= 0;
      hold_cnt <= 0;
      hold_taken <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else if (!gaps_on) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= (stall_phase % 64 < 48) ? ($urandom_range(0, 3) != 0)
                                                 : ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Monitor: each weight against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected weight %0d with nothing outstanding", m_axis_tdata[16:0]);
      end else begin
        automatic logic [16:0] want = weight_q.pop_front();
        if (m_axis_tdata[16:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("weight mismatch: expected %0d got %0d", want, m_axis_tdata[16:0]);
        end
      end
    end
  end

  // One APB write; pready is always high, so setup plus access is enough.
  task automatic apb_write(input hbw_pkg::reg_idx_e idx, input logic [16:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= {15'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      hbw_pkg::REG_START:  cur_start = value;
      hbw_pkg::REG_DELAY:  cur_delay = value;
      default:             cur_smooth = value;
    endcase
  endtask

  // Waits until every queued sample is taken and every weight has returned.
  task automatic drain();
    while (level_q.size() != 0 || s_axis_tvalid || weight_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_curve(input logic [16:0] st, input logic [16:0] dl,
                           input logic [16:0] sm);
    drain();
    apb_write(hbw_pkg::REG_START, st);
    apb_write(hbw_pkg::REG_DELAY, dl);
    apb_write(hbw_pkg::REG_SMOOTH, sm);
  endtask

  // Random sample, weighted toward the window so the power curve is exercised.
  function automatic logic [16:0] pick_level();
    int unsigned r;
    int unsigned lo, hi;
    r = $urandom_range(0, 9);
    lo = (cur_start > 17'd65536) ? 65536 : cur_start;
    hi = lo + ((cur_delay > 17'd65536) ? 65536 : cur_delay) * 2 / 5 + 200;
    if (hi > 131071) hi = 131071;
    if (r < 6) return 17'($urandom_range(lo, hi));
    if (r < 8) return 17'($urandom_range(0, 65536));
    return 17'($urandom_range(0, 131071));
  endfunction

  logic [16:0] sweep_start[6] = '{17'd0, 17'd65536, 17'd131071,
                                  17'd65500, 17'd30000, 17'd65440};
  logic [16:0] sweep_delay[6] = '{17'd0, 17'd65536, 17'd131071,
                                  17'd1, 17'd20000, 17'd50000};
  logic [16:0] sweep_smooth[6] = '{17'd0, 17'd65536, 17'd131071,
                                   17'd32768, 17'd1000, 17'd60000};

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_start = '0;
    cur_delay = '0;
    cur_smooth = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero-width window at reset, then a mid window with extremes
    // of the sample, both window edges and a sample above 1.0.
    foreach (sweep_start[i]) level_q.push_back(i == 0 ? 17'd0 : 17'd131071);
    level_q.push_back(17'd65536);
    set_curve(17'd16384, 17'd65536, 17'd0);
    level_q.push_back(17'd0);
    level_q.push_back(17'd16384);
    level_q.push_back(17'd16385);
    level_q.push_back(17'd20000);
    level_q.push_back(17'd42598);
    level_q.push_back(17'd42599);
    level_q.push_back(17'd65536);
    level_q.push_back(17'h15555);
    set_curve(17'd65530, 17'd200, 17'd65536);  // start near 1: decay shrinks the span
    for (int i = 65400; i <= 65536; i += 17) level_q.push_back(17'(i));

    // Random phases over a sweep of curve settings, extremes included.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6) set_curve(sweep_start[ph], sweep_delay[ph], sweep_smooth[ph]);
      else set_curve(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                     17'($urandom_range(0, 131071)));
      gaps_on = (ph != 3);
      for (int n = 0; n < 80; n++) level_q.push_back(pick_level());
      if (ph == 5) begin
        // Receiver holds off long enough that the pipeline fills and
        // the input stalls while the sender keeps offering.
        hold_req = 1'b1;
      end
      if (ph == 8) begin
        while (level_q.size() > 40) @(posedge clk_i);
        sender_pause = 1'b1;
        while (weight_q.size() != 0) @(posedge clk_i);
        sender_pause = 1'b0;
      end
    end
    drain();
    repeat (PIPE_LAT + 20) @(posedge clk_i);

    $display("Checked %0d blend weights over 15 curve settings, including a zero", results_seen);
    $display("width window, start above the decay knee and long output stalls.");
    if (mismatches == 0 && weight_q.size() == 0) begin
      $display("highlight_blend_weight_curve test passed");
    end else begin
      $display("%0d mismatches, %0d weights missing", mismatches, weight_q.size());
      $display("highlight_blend_weight_curve test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d weights outstanding", weight_q.size());
    $display("highlight_blend_weight_curve test failed");
    $finish;
  end

endmodule
